>>> rtl/dbra_pkg.sv
`default_nettype none
package dbra_pkg;

   // default geometry of the buffer
   localparam int BLOCK_BYTES_DEF = 64;
   localparam int NUM_BLOCKS_DEF  = 64;
   localparam int TAG_BITS_DEF    = 16;

   // fixed field widths of the ports
   localparam int ADDR_W       = 32;
   localparam int REQ_BYTES_W  = 16;
   localparam int RUN_BLOCKS_W = 7;

   // command codes
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

endpackage
`default_nettype wire

>>> rtl/dma_block_run_allocator_core.sv
// Sequence, accepting edge to rsp_valid: an allocate runs the divider, a first-fit scan and
//   the tagging of the N blocks found (zero-size and oversize requests skip scan and tags); a
//   free runs the divider, reads the tag and clears R blocks, or, outside the buffer, answers.
// Throughput: one word at a time; the next word is taken the cycle after its result loads,
//   and loading waits while the previous result is still held in the output register.
// Reset: synchronous; a clearing pass then writes NUM_BLOCKS zero tags, one per cycle,
//   with req_ready low. buffer_base resets to 0 and the next tag to 1.
`default_nettype none
module dma_block_run_allocator_core #(
   parameter int BLOCK_BYTES = dbra_pkg::BLOCK_BYTES_DEF,
   parameter int NUM_BLOCKS  = dbra_pkg::NUM_BLOCKS_DEF,
   parameter int TAG_BITS    = dbra_pkg::TAG_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_enable,
   input  wire logic [dbra_pkg::ADDR_W-1:0]       csr_write_data,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_command,
   input  wire logic [dbra_pkg::REQ_BYTES_W-1:0]  req_request_bytes,
   input  wire logic [dbra_pkg::ADDR_W-1:0]       req_free_address,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_ok,
   output logic      [dbra_pkg::ADDR_W-1:0]       rsp_run_address,
   output logic      [dbra_pkg::RUN_BLOCKS_W-1:0] rsp_run_blocks
);
   import dbra_pkg::*;

   localparam int IDX_W     = $clog2(NUM_BLOCKS);
   localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);
   localparam int SPAN      = NUM_BLOCKS * BLOCK_BYTES;
   localparam int OFF_W     = $clog2(SPAN);
   localparam int REQ_SUM_W = $clog2(2 ** REQ_BYTES_W + BLOCK_BYTES - 1);
   localparam int DIV_W     = (OFF_W > REQ_SUM_W) ? OFF_W : REQ_SUM_W;

   localparam logic [CNT_W-1:0]  NUM_C      = CNT_W'(NUM_BLOCKS);
   localparam logic [CNT_W-1:0]  NUM_LAST_C = CNT_W'(NUM_BLOCKS - 1);
   localparam logic [DIV_W-1:0]  NUM_D      = DIV_W'(NUM_BLOCKS);
   localparam logic [DIV_W-1:0]  ROUND_D    = DIV_W'(BLOCK_BYTES - 1);
   localparam logic [ADDR_W-1:0] SPAN_A     = ADDR_W'(SPAN);
   localparam logic [ADDR_W-1:0] BB_A       = ADDR_W'(BLOCK_BYTES);

   typedef enum logic [3:0] {
      ST_INIT,   // clearing pass over the owner memory
      ST_IDLE,   // wait for a request word
      ST_DIV,    // bytes to blocks, or address to block index
      ST_SCAN,   // first-fit search, one block per cycle
      ST_MARK,   // tag the run found
      ST_FRD,    // read the tag of the addressed block
      ST_FTAG,   // latch the tag
      ST_CLEAR,  // clear blocks that carry the tag
      ST_RESP    // hand the result to the output register
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       ptr_ff, ptr_in;
   logic                   chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]       chk_idx_ff, chk_idx_in;
   logic [CNT_W-1:0]       run_ff, run_in;
   logic [IDX_W-1:0]       start_ff, start_in;
   logic [CNT_W-1:0]       need_ff, need_in;
   logic [CNT_W-1:0]       left_ff, left_in;
   logic                   cmd_ff, cmd_in;
   logic [TAG_BITS-1:0]    tag_ff, tag_in;
   logic [TAG_BITS-1:0]    next_tag_ff, next_tag_in;
   logic [ADDR_W-1:0]      base_ff;
   logic                   res_ok_ff, res_ok_in;
   logic [CNT_W-1:0]       res_blk_ff, res_blk_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_ok_ff, rsp_ok_in;
   logic [ADDR_W-1:0]      rsp_addr_ff, rsp_addr_in;
   logic [RUN_BLOCKS_W-1:0] rsp_blk_ff, rsp_blk_in;

   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   logic [TAG_BITS-1:0]    mem_wdata;
   logic [IDX_W-1:0]       mem_raddr;
   logic [TAG_BITS-1:0]    mem_rdata;

   logic                   div_start;
   logic [DIV_W-1:0]       div_dividend;
   logic                   div_done;
   logic [DIV_W-1:0]       div_quotient;

   logic                   req_take;
   logic [ADDR_W-1:0]      free_offset;
   logic [TAG_BITS-1:0]    tag_inc;
   logic [CNT_W-1:0]       run_next;
   logic [IDX_W-1:0]       start_next;
   logic [CNT_W-1:0]       ptr_inc;

   dbra_div #(
      .DIVISOR (BLOCK_BYTES),
      .DVD_W   (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .done     (div_done),
      .quotient (div_quotient)
   );

   dbra_mem #(
      .DEPTH (NUM_BLOCKS),
      .WIDTH (TAG_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign req_ready   = (state_ff == ST_IDLE);
   assign req_take    = req_valid && req_ready;
   assign free_offset = req_free_address - base_ff;
   assign tag_inc     = TAG_BITS'(next_tag_ff + 1'b1);
   assign ptr_inc     = CNT_W'(ptr_ff + 1'b1);

   // scan step: a run opens at the block checked while the count is empty
   assign start_next = (run_ff == '0) ? chk_idx_ff : start_ff;
   assign run_next   = (mem_rdata != '0) ? '0 : CNT_W'(run_ff + 1'b1);

   // the round-up add or the buffer offset feeds the shared divider
   assign div_start    = req_take && !(req_command == CMD_FREE && free_offset >= SPAN_A);
   assign div_dividend = (req_command == CMD_FREE) ? DIV_W'(free_offset[OFF_W-1:0])
                                                   : DIV_W'(req_request_bytes) + ROUND_D;

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      chk_vld_in   = chk_vld_ff;
      chk_idx_in   = chk_idx_ff;
      run_in       = run_ff;
      start_in     = start_ff;
      need_in      = need_ff;
      left_in      = left_ff;
      cmd_in       = cmd_ff;
      tag_in       = tag_ff;
      next_tag_in  = next_tag_ff;
      res_ok_in    = res_ok_ff;
      res_blk_in   = res_blk_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_blk_in   = rsp_blk_ff;
      mem_we       = 1'b0;
      mem_waddr    = ptr_ff[IDX_W-1:0];
      mem_wdata    = '0;
      mem_raddr    = '0;

      // drop the result word once the consumer takes it
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_INIT: begin
            mem_we = 1'b1;
            ptr_in = ptr_inc;
            if (ptr_ff == NUM_LAST_C) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_take) begin
               cmd_in     = req_command;
               res_blk_in = '0;
               start_in   = '0;
               if (div_start) begin
                  state_in = ST_DIV;
               end else begin
                  // free address outside the buffer
                  res_ok_in = 1'b0;
                  state_in  = ST_RESP;
               end
            end
         end

         ST_DIV: begin
            if (div_done) begin
               if (cmd_ff == CMD_FREE) begin
                  ptr_in   = CNT_W'(div_quotient[IDX_W-1:0]);
                  state_in = ST_FRD;
               end else if (div_quotient == '0) begin
                  // zero-byte request: succeed at block 0, tag nothing
                  res_ok_in   = 1'b1;
                  next_tag_in = (tag_inc == '0) ? TAG_BITS'(1) : tag_inc;
                  state_in    = ST_RESP;
               end else if (div_quotient > NUM_D) begin
                  res_ok_in = 1'b0;
                  state_in  = ST_RESP;
               end else begin
                  need_in    = div_quotient[CNT_W-1:0];
                  ptr_in     = '0;
                  run_in     = '0;
                  chk_vld_in = 1'b0;
                  state_in   = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // issue the next read while the previous word comes back
            if (ptr_ff < NUM_C) begin
               mem_raddr  = ptr_ff[IDX_W-1:0];
               ptr_in     = ptr_inc;
               chk_vld_in = 1'b1;
               chk_idx_in = ptr_ff[IDX_W-1:0];
            end else begin
               chk_vld_in = 1'b0;
            end
            if (chk_vld_ff) begin
               start_in = start_next;
               run_in   = run_next;
               if (run_next >= need_ff) begin
                  ptr_in     = CNT_W'(start_next);
                  left_in    = need_ff;
                  chk_vld_in = 1'b0;
                  state_in   = ST_MARK;
               end
            end else if (ptr_ff == NUM_C) begin
               res_ok_in = 1'b0;
               state_in  = ST_RESP;
            end
         end

         ST_MARK: begin
            mem_we    = 1'b1;
            mem_wdata = next_tag_ff;
            ptr_in    = ptr_inc;
            left_in   = CNT_W'(left_ff - 1'b1);
            if (left_ff == CNT_W'(1)) begin
               res_ok_in   = 1'b1;
               res_blk_in  = need_ff;
               next_tag_in = (tag_inc == '0) ? TAG_BITS'(1) : tag_inc;
               state_in    = ST_RESP;
            end
         end

         ST_FRD: begin
            mem_raddr = ptr_ff[IDX_W-1:0];
            state_in  = ST_FTAG;
         end

         ST_FTAG: begin
            tag_in    = mem_rdata;
            res_ok_in = 1'b1;
            if (mem_rdata == '0) begin
               state_in = ST_RESP;
            end else begin
               mem_raddr = ptr_ff[IDX_W-1:0];
               state_in  = ST_CLEAR;
            end
         end

         ST_CLEAR: begin
            // clear this block and fetch the next one in the same cycle
            if (mem_rdata == tag_ff) begin
               mem_we     = 1'b1;
               res_blk_in = CNT_W'(res_blk_ff + 1'b1);
               if (ptr_inc < NUM_C) begin
                  mem_raddr = ptr_inc[IDX_W-1:0];
                  ptr_in    = ptr_inc;
               end else begin
                  state_in = ST_RESP;
               end
            end else begin
               state_in = ST_RESP;
            end
         end

         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_blk_in   = RUN_BLOCKS_W'(res_blk_ff);
               rsp_addr_in  = (res_ok_ff && cmd_ff == CMD_ALLOC)
                              ? base_ff + ADDR_W'(start_ff) * BB_A : '0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      chk_idx_ff  <= chk_idx_in;
      run_ff      <= run_in;
      start_ff    <= start_in;
      need_ff     <= need_in;
      left_ff     <= left_in;
      cmd_ff      <= cmd_in;
      tag_ff      <= tag_in;
      res_ok_ff   <= res_ok_in;
      res_blk_ff  <= res_blk_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_blk_ff  <= rsp_blk_in;
      if (reset) begin
         state_ff     <= ST_INIT;
         ptr_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         next_tag_ff  <= TAG_BITS'(1);
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         chk_vld_ff   <= chk_vld_in;
         next_tag_ff  <= next_tag_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            base_ff <= csr_write_data;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_run_address = rsp_addr_ff;
   assign rsp_run_blocks  = rsp_blk_ff;

endmodule
`default_nettype wire

>>> rtl/dbra_div.sv
`default_nettype none
module dbra_div #(
   parameter int DIVISOR = 64,
   parameter int DVD_W   = 17
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   output logic                  done,
   output logic      [DVD_W-1:0] quotient
);
   // floor(x / DIVISOR) equals (x * RECIP) >> SHIFT for every x below 2**DVD_W
   localparam int SHIFT   = DVD_W + $clog2(DIVISOR);
   localparam int RECIP_W = DVD_W + 2;
   localparam int PROD_W  = DVD_W + RECIP_W;
   localparam logic [63:0] RECIP_L =
      ((64'd1 << SHIFT) + 64'(DIVISOR - 1)) / 64'(DIVISOR);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic             done_ff, done_in;

   // reciprocal multiply, quotient ready the cycle after start
   always_comb begin
      quo_in  = quo_ff;
      done_in = start;
      if (start) begin
         quo_in = DVD_W'((PROD_W'(dividend) * PROD_W'(RECIP)) >> SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

>>> rtl/dbra_mem.sv
`default_nettype none
module dbra_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] owner_mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         owner_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= owner_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> rtl/dbra_checker.sv
`default_nettype none
module dbra_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic                              rsp_ok,
   input wire logic [dbra_pkg::ADDR_W-1:0]       rsp_run_address,
   input wire logic [dbra_pkg::RUN_BLOCKS_W-1:0] rsp_run_blocks
);
   import dbra_pkg::*;

   logic [1:0] pend_ff, pend_in;
   logic       req_take;
   logic       rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // words accepted but not yet delivered
   always_comb begin
      pend_in = pend_ff;
      if (req_take && !rsp_take) begin
         pend_in = 2'(pend_ff + 1'b1);
      end else if (!req_take && rsp_take) begin
         pend_in = 2'(pend_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok)
         && $stable(rsp_run_address) && $stable(rsp_run_blocks))
      else $error("result word changed while stalled");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_run_address == '0 && rsp_run_blocks == '0)
      else $error("failed result carries an address or block count");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result word without a request word");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_take |-> pend_ff < 2'd2)
      else $error("request taken while two words are outstanding");

endmodule

bind dma_block_run_allocator_core dbra_checker u_dbra_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_ok          (rsp_ok),
   .rsp_run_address (rsp_run_address),
   .rsp_run_blocks  (rsp_run_blocks)
);
`default_nettype wire
